/* rtl/assert_macros.svh */
// Assertion macros shared by the keypad debouncer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Concurrent check on clk_i, disabled while rst_ni is low.
`define KDHR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check with explicit clock and active-low reset.
`define KDHR_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`else

`define KDHR_ASSERT(label, prop, msg)
`define KDHR_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

`endif

/* rtl/kdhr_pkg.sv */
// Types and constants of the keypad debouncer with hold and repeat.
`default_nettype none

package kdhr_pkg;

  localparam int unsigned PinBits   = 9;
  localparam int unsigned DebW      = 8;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned KeyNumW   = 4;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 4;

  localparam logic [DebW-1:0]  DebounceLimitRst = 8'd5;
  localparam logic [HoldW-1:0] HoldLimitRst     = 16'd50;
  localparam logic [HoldW-1:0] RepeatLimitRst   = 16'd100;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_REPEAT   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_UP   = 3'b001,
    MODE_DOWN = 3'b010,
    MODE_HOLD = 3'b100
  } key_mode_e;

  // Per-key status after the current tick's update.
  typedef struct packed {
    logic pressed;
    logic held;
    logic press_evt;
    logic chg;
  } lane_stat_t;

  typedef struct packed {
    logic [PinBits-1:0] pressed_mask;
    logic [PinBits-1:0] held_mask;
    logic [KeyNumW-1:0] recent_key;
    logic               changed;
  } result_t;

  typedef struct packed {
    logic [DebW-1:0]  debounce_limit;
    logic [HoldW-1:0] hold_limit;
    logic [HoldW-1:0] repeat_limit;
  } limits_t;

endpackage

`default_nettype wire

/* rtl/kdhr_lane.sv */
// One key's debounce, hold and repeat state machine.
`default_nettype none

module kdhr_lane
  import kdhr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       down_i,
  input  wire limits_t    lim_i,
  output lane_stat_t      stat_o
);

  `include "assert_macros.svh"

  key_mode_e        mode_q, mode_d;
  logic [DebW-1:0]  deb_q, deb_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic [DebW:0]    deb_next;
  logic [HoldW:0]   hold_next;
  logic             deb_hit;
  logic             chg;
  logic             press_evt;

  // Counts are compared one bit wider so a saturated hold count still meets any limit.
  assign deb_next  = {1'b0, deb_q} + (DebW+1)'(1);
  assign hold_next = {1'b0, hold_q} + (HoldW+1)'(1);
  assign deb_hit   = deb_next >= {1'b0, lim_i.debounce_limit};

  always_comb begin
    mode_d    = mode_q;
    deb_d     = deb_q;
    hold_d    = hold_q;
    chg       = 1'b0;
    press_evt = 1'b0;
    case (mode_q)
      MODE_DOWN: begin
        if (down_i) begin
          hold_d = hold_next[HoldW] ? {HoldW{1'b1}} : hold_next[HoldW-1:0];
          if (hold_next >= {1'b0, lim_i.hold_limit}) begin
            mode_d = MODE_HOLD;
            chg    = 1'b1;
          end
        end else if (deb_hit) begin
          deb_d  = '0;
          mode_d = MODE_UP;
          hold_d = '0;
          chg    = 1'b1;
        end else begin
          deb_d = deb_next[DebW-1:0];
        end
      end
      MODE_HOLD: begin
        if (down_i) begin
          if (hold_next >= {1'b0, lim_i.repeat_limit}) begin
            hold_d = '0;
            chg    = 1'b1;
          end else begin
            hold_d = hold_next[HoldW-1:0];
          end
        end else if (deb_hit) begin
          deb_d  = '0;
          mode_d = MODE_UP;
          hold_d = '0;
          chg    = 1'b1;
        end else begin
          deb_d = deb_next[DebW-1:0];
        end
      end
      default: begin
        if (down_i) begin
          if (deb_hit) begin
            deb_d     = '0;
            mode_d    = MODE_DOWN;
            hold_d    = '0;
            chg       = 1'b1;
            press_evt = 1'b1;
          end else begin
            deb_d = deb_next[DebW-1:0];
          end
        end else begin
          deb_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_UP;
      deb_q  <= '0;
      hold_q <= '0;
    end else if (en_i) begin
      mode_q <= mode_d;
      deb_q  <= deb_d;
      hold_q <= hold_d;
    end
  end

  assign stat_o.pressed   = (mode_d == MODE_DOWN) || (mode_d == MODE_HOLD);
  assign stat_o.held      = (mode_d == MODE_HOLD);
  assign stat_o.press_evt = press_evt;
  assign stat_o.chg       = chg;

  `KDHR_ASSERT(a_rel_idle_clears, en_i && (mode_q == MODE_UP) && !down_i |=> deb_q == '0, "idle count kept")
  `KDHR_ASSERT(a_press_clears_hold, en_i && press_evt |=> (mode_q == MODE_DOWN) && (hold_q == '0), "hold not cleared")
  `KDHR_ASSERT(a_hold_frozen, !en_i |=> $stable(hold_q) && $stable(mode_q), "lane moved while idle")

endmodule

`default_nettype wire

/* rtl/kdhr_merge.sv */
// Merges lane status into one result and buffers it toward the output.
`default_nettype none

module kdhr_merge
  import kdhr_pkg::*;
#(
  parameter int unsigned NumKeys = 9
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_fire_i,
  input  wire lane_stat_t [NumKeys-1:0] stat_i,
  input  wire logic                    out_stall_i,
  output logic                         out_valid_o,
  output logic                         full_o,
  output result_t                      res_o
);

  `include "assert_macros.svh"

  logic [KeyNumW-1:0] last_q, last_d;
  logic [NumKeys-1:0] chg_vec;
  logic [PinBits-1:0] pmask, hmask;
  result_t            res_new;
  result_t            out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               out_fire;
  logic               out_load;

  for (genvar k = 0; k < PinBits; k++) begin : g_mask
    if (k < NumKeys) begin : g_key
      assign pmask[k] = stat_i[k].pressed;
      assign hmask[k] = stat_i[k].held;
    end else begin : g_nokey
      assign pmask[k] = 1'b0;
      assign hmask[k] = 1'b0;
    end
  end

  for (genvar k = 0; k < NumKeys; k++) begin : g_chg
    assign chg_vec[k] = stat_i[k].chg;
  end

  // Highest-numbered key pressed this tick wins; keys without a pin report none.
  always_comb begin
    last_d = last_q;
    for (int unsigned k = 0; k < NumKeys; k++) begin
      if (stat_i[k].press_evt) begin
        last_d = (k < PinBits) ? KeyNumW'(k + 1) : '0;
      end
    end
  end

  assign res_new.pressed_mask = pmask;
  assign res_new.held_mask    = hmask;
  assign res_new.recent_key   = last_d;
  assign res_new.changed      = |chg_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (in_fire_i) begin
      last_q <= last_d;
    end
  end

  assign out_fire = out_valid_q && !out_stall_i;
  assign out_load = !out_valid_q || out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= skid_valid_q || in_fire_i;
      end
      if (skid_valid_q && out_load) begin
        skid_valid_q <= 1'b0;
      end else if (in_fire_i && !out_load) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end
    if (in_fire_i && !out_load) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign full_o      = skid_valid_q;
  assign res_o       = out_q;

  `KDHR_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid entry without output entry")
  `KDHR_ASSERT(a_no_overrun, skid_valid_q |-> !in_fire_i, "transaction taken into a full buffer")
  `KDHR_ASSERT(a_stalled_kept, out_valid_q && out_stall_i |=> out_valid_q, "stalled result dropped")

endmodule

`default_nettype wire

/* rtl/keypad_debounce_hold_repeat.sv */
// Top level: keypad debouncer with hold and auto-repeat, one lane per key.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o  pin_levels_i
//   out      source     out_valid_o / out_stall_i pressed_mask_o, held_mask_o,
//                                                last_key_number_o, changed_o
//   cfg      APB slave  psel/penable/pwrite      paddr, pwdata, prdata
//
// A valid scan tick is taken whenever in_stall_o is low; its result is registered before it
// shows on the out port. All key lanes update in parallel, so the rate is one tick per cycle
// while in_stall_o is low, regardless of NUM_KEYS. A two-entry output buffer takes one more
// tick while a result is stalled; in_stall_o rises only when both entries hold results.
// Reset puts every key in released with zero counts, no last key, and the limits at 5/50/100.
`default_nettype none

module keypad_debounce_hold_repeat
  import kdhr_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 9
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [PinBits-1:0] pin_levels_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [PinBits-1:0]      pressed_mask_o,
  output logic [PinBits-1:0]      held_mask_o,
  output logic [KeyNumW-1:0]      last_key_number_o,
  output logic                    changed_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  limits_t                  lim_q;
  reg_idx_e                 reg_idx;
  logic                     cfg_wr;
  logic                     in_fire;
  logic                     full;
  logic [NUM_KEYS-1:0]      down;
  lane_stat_t [NUM_KEYS-1:0] stat;
  result_t                  res;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.debounce_limit <= DebounceLimitRst;
      lim_q.hold_limit     <= HoldLimitRst;
      lim_q.repeat_limit   <= RepeatLimitRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE: lim_q.debounce_limit <= pwdata[DebW-1:0];
        REG_HOLD:     lim_q.hold_limit     <= pwdata[HoldW-1:0];
        REG_REPEAT:   lim_q.repeat_limit   <= pwdata[HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = DataW'(lim_q.debounce_limit);
      REG_HOLD:     prdata = DataW'(lim_q.hold_limit);
      REG_REPEAT:   prdata = DataW'(lim_q.repeat_limit);
      default:      prdata = '0;
    endcase
  end

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  // Keys past the pin vector read as released.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    if (k < PinBits) begin : g_pin
      assign down[k] = !pin_levels_i[k];
    end else begin : g_nopin
      assign down[k] = 1'b0;
    end

    kdhr_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (in_fire),
      .down_i (down[k]),
      .lim_i  (lim_q),
      .stat_o (stat[k])
    );
  end

  kdhr_merge #(
    .NumKeys (NUM_KEYS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .stat_i      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .full_o      (full),
    .res_o       (res)
  );

  assign pressed_mask_o    = res.pressed_mask;
  assign held_mask_o       = res.held_mask;
  assign last_key_number_o = res.recent_key;
  assign changed_o         = res.changed;

endmodule

`default_nettype wire
